// ===== sv/cmps_pkg.sv =====
// Shared constants, types and lookup functions for the CAN motor position sequencer.
`timescale 1ns / 1ps

package cmps_pkg;

  localparam int unsigned NumMotors = 6;
  localparam int unsigned MotorW    = 3;
  localparam int unsigned CanIdW    = 11;
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned TargetW   = 32;
  localparam int unsigned ParamW    = 16;
  localparam int unsigned TickW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 96;

  localparam logic [7:0]        CmdCode     = 8'hA4;
  localparam logic [CanIdW-1:0] ReplyOffset = 11'h100;

  localparam logic [ParamW-1:0] ResendReset = 16'd10;
  localparam logic [ParamW-1:0] BandReset   = 16'd100;

  localparam logic [CfgIdxW-1:0] CfgResend = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgBand   = 3'd7;

  localparam logic [MotorW-1:0] LastMotor = MotorW'(NumMotors - 1);

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_SENT    = 2'd1,
    EVT_FB      = 2'd2,
    EVT_REACHED = 2'd3
  } evt_e;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_FRAME = 1'b1
  } act_e;

  function automatic logic [CanIdW-1:0] motor_can_id(input logic [MotorW-1:0] m);
    logic [CanIdW-1:0] id;
    unique case (m)
      3'd0:    id = 11'h142;
      3'd1:    id = 11'h144;
      3'd2:    id = 11'h145;
      3'd3:    id = 11'h146;
      3'd4:    id = 11'h147;
      3'd5:    id = 11'h148;
      default: id = 11'h142;
    endcase
    return id;
  endfunction

  function automatic logic [ParamW-1:0] motor_speed(input logic [MotorW-1:0] m);
    logic [ParamW-1:0] s;
    unique case (m)
      3'd0:    s = 16'd300;
      3'd5:    s = 16'd75;
      default: s = 16'd50;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/cmps_eval.sv =====
// Feedback evaluation: checks whether a reported angle lies inside the band around the target.
`timescale 1ns / 1ps

module cmps_eval (
  input  logic signed [cmps_pkg::TargetW-1:0] target_i,
  input  logic signed [cmps_pkg::AngleW-1:0]  angle_i,
  input  logic        [cmps_pkg::ParamW-1:0]  band_i,
  output logic                                reached_o
);

  localparam int unsigned ErrW = 34;

  logic signed [ErrW-1:0] angle_x;
  logic signed [ErrW-1:0] centi;
  logic signed [ErrW-1:0] err;
  logic        [ErrW-1:0] err_abs;

  // degrees to centidegrees: x*100 = x*64 + x*32 + x*4
  assign angle_x = ErrW'(angle_i);
  assign centi   = (angle_x <<< 6) + (angle_x <<< 5) + (angle_x <<< 2);
  assign err     = ErrW'(target_i) - centi;
  assign err_abs = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);

  assign reached_o = err_abs < {{(ErrW - cmps_pkg::ParamW){1'b0}}, band_i};

endmodule

// ===== sv/can_motor_position_sequencer_core.sv =====
// Top level: six-motor CAN position command sequencer with feedback-driven advance.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                   | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser action, tdata frame_id, frame_payload
// m_axis    | out | m_axis_tvalid/m_axis_tready | tuser event_res, tdata result fields
// cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i register, cfg_data_i value
//
// One item per clock unless the output stalls; input register, then result register.
// Per-motor state and the tick counter update when the held item moves into the
// result register, so each item sees everything its predecessors left.
// A stalled output holds the result register and the input register in turn.
// Reset clears all control state; targets return to 0, interval 10, band 100.

module can_motor_position_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic                                s_axis_tuser,  // [0] action
  input  logic [cmps_pkg::InDataW-1:0]        s_axis_tdata,  // [10:0] frame_id,
                                                             // [74:11] frame_payload
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [1:0]                          m_axis_tuser,  // [1:0] event_res
  output logic [cmps_pkg::OutDataW-1:0]       m_axis_tdata,  // [2:0] motor_index,
                                                             // [13:3] cmd_id,
                                                             // [77:14] cmd_payload,
                                                             // [93:78] feedback_angle,
                                                             // [94] cycle_done
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cmps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cmps_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned N = cmps_pkg::NumMotors;

  // configuration
  logic [cmps_pkg::TargetW-1:0] target_q [N];
  logic [cmps_pkg::ParamW-1:0]  resend_q;
  logic [cmps_pkg::ParamW-1:0]  band_q;

  // sequencer state
  logic [cmps_pkg::MotorW-1:0]  cur_q;
  logic [N-1:0]                 reached_q;
  logic [N-1:0]                 sent_q;
  logic [cmps_pkg::TickW-1:0]   last_tick_q [N];
  logic [cmps_pkg::TickW-1:0]   tick_q;

  // input register
  logic                          in_valid_q;
  logic                          in_action_q;
  logic [cmps_pkg::CanIdW-1:0]   in_id_q;
  logic [cmps_pkg::PayloadW-1:0] in_payload_q;

  // result register
  logic                          out_valid_q;
  cmps_pkg::evt_e                out_evt_q;
  logic [cmps_pkg::MotorW-1:0]   out_motor_q;
  logic [cmps_pkg::CanIdW-1:0]   out_cid_q;
  logic [cmps_pkg::PayloadW-1:0] out_cpl_q;
  logic [cmps_pkg::AngleW-1:0]   out_fb_q;
  logic                          out_wrap_q;

  logic                          advance;
  logic                          load;
  logic                          is_tick;
  logic [cmps_pkg::TickW-1:0]    tick_d;
  logic [cmps_pkg::TickW-1:0]    elapsed;
  logic                          send;
  logic                          frame_hit;
  logic [cmps_pkg::AngleW-1:0]   raw_angle;
  logic                          fb_reached;
  logic                          reach;
  logic                          wrap;
  cmps_pkg::evt_e                evt_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign load          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign is_tick   = (cmps_pkg::act_e'(in_action_q) == cmps_pkg::ACT_TICK);
  assign tick_d    = tick_q + cmps_pkg::TickW'(1);
  assign elapsed   = tick_d - last_tick_q[cur_q];
  assign send      = is_tick && !reached_q[cur_q] &&
                     (!sent_q[cur_q] ||
                      elapsed >= {{(cmps_pkg::TickW - cmps_pkg::ParamW){1'b0}}, resend_q});
  assign frame_hit = !is_tick &&
                     (in_id_q == cmps_pkg::motor_can_id(cur_q) + cmps_pkg::ReplyOffset) &&
                     (in_payload_q[7:0] == cmps_pkg::CmdCode);
  assign raw_angle = in_payload_q[63:48];
  assign reach     = frame_hit && fb_reached;
  assign wrap      = reach && (cur_q == cmps_pkg::LastMotor);

  cmps_eval u_eval (
    .target_i  (target_q[cur_q]),
    .angle_i   (raw_angle),
    .band_i    (band_q),
    .reached_o (fb_reached)
  );

  always_comb begin
    if (send) begin
      evt_d = cmps_pkg::EVT_SENT;
    end else if (reach) begin
      evt_d = cmps_pkg::EVT_REACHED;
    end else if (frame_hit) begin
      evt_d = cmps_pkg::EVT_FB;
    end else begin
      evt_d = cmps_pkg::EVT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        target_q[i] <= '0;
      end
      resend_q <= cmps_pkg::ResendReset;
      band_q   <= cmps_pkg::BandReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cmps_pkg::CfgResend) begin
        resend_q <= cfg_data_i[cmps_pkg::ParamW-1:0];
      end else if (cfg_index_i == cmps_pkg::CfgBand) begin
        band_q <= cfg_data_i[cmps_pkg::ParamW-1:0];
      end else if (cfg_index_i < cmps_pkg::CfgIdxW'(N)) begin
        target_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_action_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q  <= s_axis_tvalid;
      in_action_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_id_q      <= s_axis_tdata[10:0];
      in_payload_q <= s_axis_tdata[74:11];
    end
  end

  // sequencer state, advanced as the held item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      reached_q <= '0;
      sent_q    <= '0;
      tick_q    <= '0;
      for (int i = 0; i < N; i++) begin
        last_tick_q[i] <= '0;
      end
    end else if (load) begin
      if (is_tick) begin
        tick_q <= tick_d;
      end
      if (send) begin
        sent_q[cur_q]      <= 1'b1;
        last_tick_q[cur_q] <= tick_d;
      end
      if (wrap) begin
        cur_q     <= '0;
        reached_q <= '0;
      end else if (reach) begin
        cur_q            <= cur_q + cmps_pkg::MotorW'(1);
        reached_q[cur_q] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_evt_q   <= cmps_pkg::EVT_NONE;
      out_wrap_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        out_evt_q  <= evt_d;
        out_wrap_q <= wrap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_motor_q <= cur_q;
      out_cid_q   <= send ? cmps_pkg::motor_can_id(cur_q) : '0;
      out_cpl_q   <= send ? {target_q[cur_q], cmps_pkg::motor_speed(cur_q), 8'h00,
                             cmps_pkg::CmdCode} : '0;
      out_fb_q    <= frame_hit ? raw_angle : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_evt_q;
  assign m_axis_tdata  = {1'b0, out_wrap_q, out_fb_q, out_cpl_q, out_cid_q, out_motor_q};

`ifndef NO_ASSERTIONS
  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= cmps_pkg::LastMotor)
    else $error("current motor out of range");

  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && wrap |=> cur_q == '0 && reached_q == '0)
    else $error("wrap did not clear reached marks");

  a_wrap_is_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_wrap_q |-> out_evt_q == cmps_pkg::EVT_REACHED &&
      out_motor_q == cmps_pkg::LastMotor)
    else $error("cycle_done without reach of last motor");

  a_cmd_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_evt_q != cmps_pkg::EVT_SENT |-> out_cid_q == '0 && out_cpl_q == '0)
    else $error("command fields set without a send");

  a_no_send_when_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && reached_q[cur_q] |-> !send)
    else $error("command sent to a reached motor");
`endif

endmodule

// ===== tb/tb_can_motor_position_sequencer_core.sv =====
// Self-checking testbench for the six-motor CAN position sequencer core.
`timescale 1ns / 1ps

module tb_can_motor_position_sequencer_core;
  import cmps_pkg::*;

  localparam int                 CycleLimit  = 300000;
  localparam int                 LongHold    = 400;
  localparam logic [CfgIdxW-1:0] CfgTarget0  = 3'd0;
  localparam logic [10:0]        ReplyOfs    = 11'h100;
  localparam logic [7:0]         PosCmd      = 8'hA4;
  localparam int                 TgtRandom   = 0;
  localparam int                 TgtExtreme  = 1;
  localparam int                 TgtWhole    = 2;
  localparam int                 PickRandom  = -1;

  localparam logic [10:0] MotorIds [6]    = '{11'h142, 11'h144, 11'h145,
                                              11'h146, 11'h147, 11'h148};
  localparam logic [15:0] MotorSpeeds [6] = '{16'd300, 16'd50, 16'd50,
                                              16'd50, 16'd50, 16'd75};

  typedef struct packed {
    evt_e        evt;
    logic [2:0]  motor;
    logic [10:0] cmd_id;
    logic [63:0] cmd_pl;
    logic [15:0] fb_angle;
    logic        wrap;
  } motor_event_t;

  typedef struct {
    act_e         act;
    logic [10:0]  fid;
    logic [63:0]  pl;
    bit           typed;
    motor_event_t res;
  } stim_row_t;

  typedef struct {
    int resend;
    int band;
    int tgt_mode;
    int tx_pct;
    int rx_pct;
    int n_items;
    bit long_hold;
  } phase_t;

  localparam motor_event_t Blank = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic                s_axis_tuser  = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [1:0]          m_axis_tuser;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Predictor state
  logic signed [31:0] tgt_cdeg [6];
  logic [15:0]        resend_ticks;
  logic [15:0]        reach_band;
  logic [2:0]         cur_motor;
  bit                 mark_reached [6];
  bit                 cmd_sent [6];
  logic [31:0]        last_cmd_tick [6];
  logic [31:0]        tick_cnt;

  motor_event_t pending_events [$];
  int           fail_cnt     = 0;
  int           cycle_cnt    = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_left = 0;

  bit           dir_has_exp = 1'b0;
  motor_event_t dir_exp     = '0;

  stim_row_t dir_rows [25] = '{
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_SENT, 3'd0, 11'h142, 64'h0000_0000_012C_00A4, 16'h0, 1'b0}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_NONE, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{EVT_NONE, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h000, 64'h0, 1'b1,
      '{EVT_NONE, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h242, 64'h0000_0000_0000_00A5, 1'b1,
      '{EVT_NONE, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h242, 64'h7FFF_FFFF_FFFF_FFA4, 1'b1,
      '{EVT_FB, 3'd0, 11'h0, 64'h0, 16'h7FFF, 1'b0}},
    '{ACT_FRAME, 11'h242, 64'h8000_0000_0000_00A4, 1'b1,
      '{EVT_FB, 3'd0, 11'h0, 64'h0, 16'h8000, 1'b0}},
    '{ACT_FRAME, 11'h244, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_NONE, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h242, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_REACHED, 3'd0, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_SENT, 3'd1, 11'h144, 64'h0000_0000_0032_00A4, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h244, 64'h0001_0000_0000_00A4, 1'b1,
      '{EVT_FB, 3'd1, 11'h0, 64'h0, 16'h0001, 1'b0}},
    '{ACT_FRAME, 11'h244, 64'hFFFF_0000_0000_00A4, 1'b1,
      '{EVT_FB, 3'd1, 11'h0, 64'h0, 16'hFFFF, 1'b0}},
    '{ACT_FRAME, 11'h244, 64'h0000_FFFF_FFFF_FFA4, 1'b1,
      '{EVT_REACHED, 3'd1, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_SENT, 3'd2, 11'h145, 64'h0000_0000_0032_00A4, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h245, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_REACHED, 3'd2, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h246, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_REACHED, 3'd3, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h247, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_REACHED, 3'd4, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_SENT, 3'd5, 11'h148, 64'h0000_0000_004B_00A4, 16'h0, 1'b0}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b1,
      '{EVT_NONE, 3'd5, 11'h0, 64'h0, 16'h0, 1'b0}},
    '{ACT_FRAME, 11'h248, 64'h0000_0000_0000_00A4, 1'b1,
      '{EVT_REACHED, 3'd5, 11'h0, 64'h0, 16'h0, 1'b1}},
    '{ACT_TICK,  11'h000, 64'h0, 1'b0, Blank},
    '{ACT_TICK,  11'h000, 64'h0, 1'b0, Blank},
    '{ACT_TICK,  11'h000, 64'h0, 1'b0, Blank},
    '{ACT_TICK,  11'h000, 64'h0, 1'b0, Blank},
    '{ACT_TICK,  11'h000, 64'h0, 1'b0, Blank}
  };

  // Zero interval and zero band first, then the extremes, then random settings
  phase_t phase_plan [8] = '{
    '{0,          0,          TgtRandom,  0,  0,  150, 1'b0},
    '{1,          65535,      TgtRandom,  51, 0,  183, 1'b0},
    '{65535,      1,          TgtWhole,   0,  51, 183, 1'b0},
    '{10,         100,        TgtExtreme, 31, 31, 183, 1'b0},
    '{PickRandom, PickRandom, TgtRandom,  0,  0,  183, 1'b1},
    '{PickRandom, PickRandom, TgtWhole,   51, 0,  183, 1'b0},
    '{PickRandom, PickRandom, TgtRandom,  0,  51, 183, 1'b0},
    '{PickRandom, PickRandom, TgtRandom,  31, 31, 183, 1'b0}
  };

  can_motor_position_sequencer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Work out the event of one accepted item and advance the sequencer state
  function automatic motor_event_t predict_motor_event(act_e act, logic [10:0] fid,
                                                       logic [63:0] pl);
    motor_event_t r;
    logic [2:0]   m;
    logic [15:0]  ang;
    longint       err;
    r = '0;
    if (cur_motor > 3'd5) cur_motor = 3'd0;
    m = cur_motor;
    r.motor = m;
    if (act == ACT_TICK) begin
      tick_cnt = tick_cnt + 32'd1;
      if (!mark_reached[m] &&
          (!cmd_sent[m] || (tick_cnt - last_cmd_tick[m]) >= 32'(resend_ticks))) begin
        r.evt    = EVT_SENT;
        r.cmd_id = MotorIds[m];
        r.cmd_pl = {tgt_cdeg[m], MotorSpeeds[m], 8'h00, PosCmd};
        cmd_sent[m]      = 1'b1;
        last_cmd_tick[m] = tick_cnt;
      end
    end else if (fid == MotorIds[m] + ReplyOfs && pl[7:0] == PosCmd) begin
      ang = pl[63:48];
      err = longint'(tgt_cdeg[m]) - longint'($signed(ang)) * 100;
      if (err < 0) err = -err;
      r.fb_angle = ang;
      if (err < longint'(reach_band)) begin
        r.evt = EVT_REACHED;
        mark_reached[m] = 1'b1;
        cur_motor = (m == 3'd5) ? 3'd0 : m + 3'd1;
        if (cur_motor == 3'd0) begin
          r.wrap = 1'b1;
          foreach (mark_reached[i]) mark_reached[i] = 1'b0;
        end
      end else begin
        r.evt = EVT_FB;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_target(int mode, int idx);
    int t;
    logic [31:0] extremes [6];
    extremes = '{32'd3276700, -32'sd3276800, 32'd0, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000};
    if (mode == TgtExtreme) return extremes[idx];
    t = int'($urandom_range(60000)) - 30000;
    if (mode == TgtWhole || $urandom_range(1) == 1) t = (t / 100) * 100;
    return t;
  endfunction

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= (int'($urandom_range(99)) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    motor_event_t got;
    motor_event_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{evt_e'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tdata[13:3],
              m_axis_tdata[77:14], m_axis_tdata[93:78], m_axis_tdata[94]};
      if (pending_events.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: evt=%0d motor=%0d", got.evt, got.motor);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: exp evt=%0d motor=%0d id=%h pl=%h fb=%h wrap=%b",
                     want.evt, want.motor, want.cmd_id, want.cmd_pl, want.fb_angle,
                     want.wrap);
            $display("          got evt=%0d motor=%0d id=%h pl=%h fb=%h wrap=%b",
                     got.evt, got.motor, got.cmd_id, got.cmd_pl, got.fb_angle,
                     got.wrap);
          end
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      want = predict_motor_event(act_e'(s_axis_tuser), s_axis_tdata[10:0],
                                 s_axis_tdata[74:11]);
      if (dir_has_exp) want = dir_exp;
      pending_events.push_back(want);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic offer_item(act_e act, logic [10:0] fid, logic [63:0] pl);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, pl, fid};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgResend: resend_ticks = val[15:0];
      CfgBand:   reach_band   = val[15:0];
      default:   tgt_cdeg[idx] = val;
    endcase
    @(negedge clk_i);
  endtask

  // Hold the input quiet until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Ticks and well-formed feedback for the motor in turn, plus noise
  task automatic random_item();
    act_e        act;
    logic [10:0] fid;
    logic [63:0] pl;
    int          roll;
    int          ang;
    logic [7:0]  code;
    roll = $urandom_range(99);
    act  = ACT_FRAME;
    pl   = {$urandom(), $urandom()};
    fid  = MotorIds[cur_motor] + ReplyOfs;
    if (roll < 45) begin
      act = ACT_TICK;
      fid = 11'($urandom_range(2047));
    end else if (roll < 85) begin
      ang = tgt_cdeg[cur_motor] / 100 + int'($urandom_range(4)) - 2;
      if ($urandom_range(2) == 0) ang = tgt_cdeg[cur_motor] / 100;
      pl[7:0]   = PosCmd;
      pl[63:48] = ang[15:0];
    end else if (roll < 90) begin
      code = 8'($urandom_range(255));
      if (code == PosCmd) code = PosCmd + 8'd1;
      pl[7:0] = code;
    end else if (roll < 95) begin
      fid = MotorIds[(int'(cur_motor) + 1 + int'($urandom_range(4))) % 6] + ReplyOfs;
      pl[7:0] = PosCmd;
    end else begin
      fid = 11'($urandom_range(2047));
    end
    offer_item(act, fid, pl);
  endtask

  initial begin
    int p;
    int n;
    int i;
    foreach (tgt_cdeg[k]) begin
      tgt_cdeg[k]      = '0;
      mark_reached[k]  = 1'b0;
      cmd_sent[k]      = 1'b0;
      last_cmd_tick[k] = '0;
    end
    resend_ticks = ResendReset;
    reach_band   = BandReset;
    cur_motor    = '0;
    tick_cnt     = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (dir_rows[r]) begin
      dir_has_exp <= dir_rows[r].typed;
      dir_exp     <= dir_rows[r].res;
      offer_item(dir_rows[r].act, dir_rows[r].fid, dir_rows[r].pl);
    end
    dir_has_exp <= 1'b0;

    for (p = 0; p < 8; p++) begin
      drain_results();
      for (i = 0; i < 6; i++)
        write_reg(CfgTarget0 + CfgIdxW'(i), pick_target(phase_plan[p].tgt_mode, i));
      write_reg(CfgResend, (phase_plan[p].resend == PickRandom) ?
                ((($urandom_range(9) == 0) ? $urandom_range(1, 65535)
                                           : $urandom_range(1, 20))) :
                phase_plan[p].resend);
      write_reg(CfgBand, (phase_plan[p].band == PickRandom) ?
                $urandom_range(1, 300) : phase_plan[p].band);
      cfg_valid_i  <= 1'b0;
      tx_idle_pct   = phase_plan[p].tx_pct;
      rx_stall_pct <= phase_plan[p].rx_pct;
      // Starve the output so the block backs up while items keep coming
      if (phase_plan[p].long_hold) rx_hold_left <= LongHold;
      for (n = 0; n < phase_plan[p].n_items; n++) random_item();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
